### rtl/biq_pkg.sv
// shared constants and request types for the biquad cascade filter
package biq_pkg;

  localparam int SECTIONS  = 8;
  localparam int N_COEF    = 5;
  localparam int COEF_W    = 24;
  localparam int COEF_FRAC = 22;
  localparam int SMP_W     = 16;
  localparam int ST_W      = 48;
  localparam int SEC_W     = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int CNT_W     = $clog2(SECTIONS + 1);
  localparam int NSEC_W    = 4;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // coefficient selector codes
  localparam int COEF_B0 = 0;
  localparam int COEF_B1 = 1;
  localparam int COEF_B2 = 2;
  localparam int COEF_A1 = 3;
  localparam int COEF_A2 = 4;

  // request modes
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  // register indexes
  localparam int REG_NUM_SECTIONS = 0;

  localparam logic signed [COEF_W-1:0] COEF_UNITY = COEF_W'(1 << COEF_FRAC);

  typedef struct packed {
    logic                     mode;
    logic signed [SMP_W-1:0]  sample_in;
    logic                     block_end;
    logic [2:0]               section_index;
    logic [2:0]               coef_select;
    logic signed [COEF_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample_out;
    logic                    clipped;
    logic                    block_end_out;
  } out_item_t;

endpackage

### rtl/biquad_cascade_filter.sv
// cascade of transposed direct-form-II biquads with coefficient and state memories
module biquad_cascade_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  biq_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output biq_pkg::out_item_t                  out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [biq_pkg::PADDR_W-1:0]         paddr,
  input  logic [biq_pkg::PDATA_W-1:0]         pwdata,
  output logic [biq_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);
  // A request with mode 1 writes one coefficient of one section; it gives no
  // result. A request with mode 0 filters one Q1.15 sample through sections
  // 0 .. num_sections-1 (capped at SECTIONS) and gives one result. Each
  // section's coefficients sit in one row of a coefficient memory and its two
  // 48-bit state words in one row of a state memory; both memories have a
  // registered read port. A section runs through a five-step pipeline: memory
  // read, the three b*x products, the rounded and saturated output y, the two
  // a*y products, then the state write-back. The next section needs only y, so
  // its memory read is issued while y is formed and the loop through y sets
  // the rate. in_ready is low from the acceptance of a sample request until
  // its result is loaded into the output register. The result goes to an
  // output register, so one waiting result does not stop the next request from
  // being taken; that next sample then holds in_ready low until the waiting
  // result leaves. After reset every section passes the sample unchanged (b0
  // is 1.0, all else zero) and all state words are zero; this is held by
  // per-entry valid bits, so no clearing pass is needed. The single register
  // num_sections (reset 1) lies at byte address 0 and should only be written
  // while no sample is in flight.
  import biq_pkg::*;

  localparam int PROD_W = COEF_W + SMP_W;
  localparam int ACC_W  = ST_W + 1;
  localparam int YSH_W  = ACC_W - COEF_FRAC;
  localparam int SUM_W  = ST_W + 2;
  localparam int ROW_W  = N_COEF * COEF_W;

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (COEF_FRAC - 1));
  localparam logic signed [YSH_W-1:0] Y_HI = YSH_W'((1 << (SMP_W - 1)) - 1);
  localparam logic signed [YSH_W-1:0] Y_LO = -YSH_W'(1 << (SMP_W - 1));
  localparam logic signed [SUM_W-1:0] ST_HI = {2'b00, 1'b0, {(ST_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ST_LO = {2'b11, 1'b1, {(ST_W-1){1'b0}}};

  // configuration
  logic [NSEC_W-1:0] num_sections_r;
  logic              cfg_wr;
  logic [PADDR_W-3:0] reg_idx;

  // memories
  logic [ROW_W-1:0]    coef_mem [SECTIONS];
  logic [N_COEF-1:0]   coef_vld_r [SECTIONS];
  logic [2*ST_W-1:0]   st_mem [SECTIONS];
  logic [SECTIONS-1:0] st_vld_r;

  logic [ROW_W-1:0]  coef_rd_r;
  logic [N_COEF-1:0] coef_rv_r;
  logic [2*ST_W-1:0] st_rd_r;
  logic              st_rv_r;

  // control
  logic             busy_r;
  logic             fin_r;
  logic [CNT_W-1:0] cnt_r;
  logic             in_acc;
  logic             coef_wr;
  logic [SEC_W-1:0] coef_wr_sec;
  logic             rd_en;
  logic [SEC_W-1:0] rd_addr;
  logic [CNT_W-1:0] cnt_new;
  logic             out_load;

  // pipeline valids and section tags
  logic             rd_v_r;
  logic [SEC_W-1:0] sec_p_r;
  logic             mv_r;
  logic [SEC_W-1:0] sec_y_r;
  logic             yv_r;
  logic [SEC_W-1:0] sec_a_r;
  logic             last_a_r;
  logic             av_r;
  logic [SEC_W-1:0] sec_w_r;
  logic             last_w_r;
  logic             last_y;

  // datapath
  logic signed [SMP_W-1:0]  x_r;
  logic signed [COEF_W-1:0] coef_q [N_COEF];
  logic signed [ST_W-1:0]   s1_q;
  logic signed [ST_W-1:0]   s2_q;
  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic signed [ST_W-1:0]   s1_r, s2_r;
  logic signed [COEF_W-1:0] a1_r, a2_r;
  logic signed [ACC_W-1:0]  acc;
  logic signed [YSH_W-1:0]  ysh;
  logic signed [SMP_W-1:0]  ysat;
  logic                     ysat_clip;
  logic signed [SMP_W-1:0]  y_r;
  logic signed [PROD_W-1:0] p1_h_r, p2_h_r;
  logic signed [ST_W-1:0]   s2_h_r;
  logic signed [COEF_W-1:0] a1_h_r, a2_h_r;
  logic signed [PROD_W-1:0] ay1_r, ay2_r;
  logic signed [SUM_W-1:0]  t1, t2;
  logic signed [ST_W-1:0]   s1_new, s2_new;
  logic signed [SMP_W-1:0]  yfin_r;
  logic                     clip_r;
  logic                     be_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready &
                   (int'(reg_idx) == REG_NUM_SECTIONS);

  always_comb begin
    prdata = '0;
    if (int'(reg_idx) == REG_NUM_SECTIONS) begin
      prdata = PDATA_W'(num_sections_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_sections_r <= NSEC_W'(1);
    end else if (cfg_wr) begin
      num_sections_r <= pwdata[NSEC_W-1:0];
    end
  end

  // ---------------------------------------------------------------- request decode
  assign in_ready = ~busy_r;
  assign in_acc   = in_valid & in_ready;

  always_comb begin
    if (int'(num_sections_r) > SECTIONS) begin
      cnt_new = CNT_W'(SECTIONS);
    end else begin
      cnt_new = CNT_W'(num_sections_r);
    end
  end

  // unknown selector or section beyond the cascade writes nothing
  assign coef_wr = in_acc && (in_data.mode == MODE_COEF) &&
                   (int'(in_data.section_index) < SECTIONS) &&
                   (int'(in_data.coef_select) < N_COEF);
  assign coef_wr_sec = SEC_W'(in_data.section_index);

  assign last_y = (int'(sec_y_r) + 1 == int'(cnt_r));

  // read section 0 on acceptance, then the next section while y is formed
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (in_acc && (in_data.mode == MODE_SAMPLE) && (cnt_new != '0)) begin
      rd_en = 1'b1;
    end else if (mv_r && !last_y) begin
      rd_en   = 1'b1;
      rd_addr = sec_y_r + SEC_W'(1);
    end
  end

  // ---------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (coef_wr) begin
      coef_mem[coef_wr_sec][in_data.coef_select*COEF_W +: COEF_W] <= in_data.coef_value;
    end
    if (rd_en) begin
      coef_rd_r <= coef_mem[rd_addr];
      st_rd_r   <= st_mem[rd_addr];
    end
    if (av_r) begin
      st_mem[sec_w_r] <= {s2_new, s1_new};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SECTIONS; i++) begin
        coef_vld_r[i] <= '0;
      end
      st_vld_r  <= '0;
      coef_rv_r <= '0;
      st_rv_r   <= 1'b0;
    end else begin
      if (coef_wr) begin
        coef_vld_r[coef_wr_sec][in_data.coef_select] <= 1'b1;
      end
      if (av_r) begin
        st_vld_r[sec_w_r] <= 1'b1;
      end
      if (rd_en) begin
        coef_rv_r <= coef_vld_r[rd_addr];
        st_rv_r   <= st_vld_r[rd_addr];
      end
    end
  end

  // entries never written read as their reset values
  always_comb begin
    for (int k = 0; k < N_COEF; k++) begin
      if (coef_rv_r[k]) begin
        coef_q[k] = coef_rd_r[k*COEF_W +: COEF_W];
      end else if (k == COEF_B0) begin
        coef_q[k] = COEF_UNITY;
      end else begin
        coef_q[k] = '0;
      end
    end
    s1_q = st_rv_r ? st_rd_r[ST_W-1:0]      : '0;
    s2_q = st_rv_r ? st_rd_r[2*ST_W-1:ST_W] : '0;
  end

  // ---------------------------------------------------------------- datapath
  // output of a section: round half up, saturate to 16 bits
  always_comb begin
    acc       = p0_r + s1_r + ROUND_HALF;
    ysh       = acc[ACC_W-1:COEF_FRAC];
    ysat_clip = 1'b0;
    if (ysh > Y_HI) begin
      ysat      = Y_HI[SMP_W-1:0];
      ysat_clip = 1'b1;
    end else if (ysh < Y_LO) begin
      ysat      = Y_LO[SMP_W-1:0];
      ysat_clip = 1'b1;
    end else begin
      ysat = ysh[SMP_W-1:0];
    end
  end

  // new state words, saturated to 48 bits
  always_comb begin
    t1 = p1_h_r + s2_h_r - ay1_r;
    t2 = p2_h_r - ay2_r;
    if (t1 > ST_HI) begin
      s1_new = ST_HI[ST_W-1:0];
    end else if (t1 < ST_LO) begin
      s1_new = ST_LO[ST_W-1:0];
    end else begin
      s1_new = t1[ST_W-1:0];
    end
    if (t2 > ST_HI) begin
      s2_new = ST_HI[ST_W-1:0];
    end else if (t2 < ST_LO) begin
      s2_new = ST_LO[ST_W-1:0];
    end else begin
      s2_new = t2[ST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    // b*x products
    if (rd_v_r) begin
      p0_r <= coef_q[COEF_B0] * x_r;
      p1_r <= coef_q[COEF_B1] * x_r;
      p2_r <= coef_q[COEF_B2] * x_r;
      s1_r <= s1_q;
      s2_r <= s2_q;
      a1_r <= coef_q[COEF_A1];
      a2_r <= coef_q[COEF_A2];
    end
    // section output, which is also the next section's input
    if (mv_r) begin
      y_r    <= ysat;
      x_r    <= ysat;
      p1_h_r <= p1_r;
      p2_h_r <= p2_r;
      s2_h_r <= s2_r;
      a1_h_r <= a1_r;
      a2_h_r <= a2_r;
    end else if (in_acc && (in_data.mode == MODE_SAMPLE)) begin
      x_r <= in_data.sample_in;
    end
    // feedback products
    if (yv_r) begin
      ay1_r <= a1_h_r * y_r;
      ay2_r <= a2_h_r * y_r;
    end
    // result of the last active section, or the input with zero sections
    if (in_acc && (in_data.mode == MODE_SAMPLE)) begin
      yfin_r <= in_data.sample_in;
      clip_r <= 1'b0;
      be_r   <= in_data.block_end;
    end else if (mv_r) begin
      clip_r <= clip_r | ysat_clip;
      if (last_y) begin
        yfin_r <= ysat;
      end
    end
    if (out_load) begin
      out_data_r.sample_out    <= yfin_r;
      out_data_r.clipped       <= clip_r;
      out_data_r.block_end_out <= be_r;
    end
  end

  // ---------------------------------------------------------------- sequencing
  assign out_load = fin_r & (~out_valid_r | out_ready);

  always_ff @(posedge clk) begin
    sec_p_r  <= rd_addr;
    sec_y_r  <= sec_p_r;
    sec_a_r  <= sec_y_r;
    last_a_r <= last_y;
    sec_w_r  <= sec_a_r;
    last_w_r <= last_a_r;
    if (in_acc && (in_data.mode == MODE_SAMPLE)) begin
      cnt_r <= cnt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      fin_r       <= 1'b0;
      rd_v_r      <= 1'b0;
      mv_r        <= 1'b0;
      yv_r        <= 1'b0;
      av_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r <= rd_en;
      mv_r   <= rd_v_r;
      yv_r   <= mv_r;
      av_r   <= yv_r;

      if (in_acc && (in_data.mode == MODE_SAMPLE)) begin
        busy_r <= 1'b1;
        // zero sections: the sample passes straight to the result
        if (cnt_new == '0) begin
          fin_r <= 1'b1;
        end
      end else if (av_r && last_w_r) begin
        fin_r <= 1'b1;
      end else if (out_load) begin
        fin_r  <= 1'b0;
        busy_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### test/biq_checker.sv
// request and result monitor with a bit-exact cascade predictor and scoreboard
`timescale 1ns / 1ps

module biq_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  biq_pkg::in_item_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  biq_pkg::out_item_t           out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [biq_pkg::PADDR_W-1:0]  paddr,
  input  logic [biq_pkg::PDATA_W-1:0]  pwdata,
  input  logic [biq_pkg::PDATA_W-1:0]  prdata,
  input  logic                         pready,
  output int                           n_errors,
  output int                           n_pending
);
  import biq_pkg::*;

  localparam longint STATE_HI   = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint STATE_LO   = -STATE_HI - 1;
  localparam longint ROUND_HALF = longint'(1) <<< (COEF_FRAC - 1);
  localparam longint SMP_HI     = 32767;
  localparam longint SMP_LO     = -32768;
  localparam logic [PADDR_W-1:0] ADDR_NSEC = PADDR_W'(4 * REG_NUM_SECTIONS);

  longint            coef_mem  [0:SECTIONS*N_COEF-1];
  longint            sec_state [0:SECTIONS*2-1];
  logic [NSEC_W-1:0] nsec;
  out_item_t         filtered_q [$];

  initial begin
    n_errors  = 0;
    n_pending = 0;
  end

  task automatic log_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("biq_checker: %0t ns: %s", $time, msg);
  endtask

  function automatic longint clamp48(input longint v);
    if (v > STATE_HI) return STATE_HI;
    if (v < STATE_LO) return STATE_LO;
    return v;
  endfunction

  task automatic clear_filter();
    for (int s = 0; s < SECTIONS; s++) begin
      for (int k = 0; k < N_COEF; k++) coef_mem[s*N_COEF+k] = 0;
      coef_mem[s*N_COEF+COEF_B0] = longint'(COEF_UNITY);
      sec_state[2*s]   = 0;
      sec_state[2*s+1] = 0;
    end
    nsec = NSEC_W'(1);
  endtask

  // one sample through the active sections, updating the state words
  task automatic run_cascade(input in_item_t it, output out_item_t res);
    longint x, acc, y;
    int     used, base;
    logic   clip;
    x    = longint'($signed(it.sample_in));
    used = (int'(nsec) > SECTIONS) ? SECTIONS : int'(nsec);
    clip = 1'b0;
    for (int s = 0; s < used; s++) begin
      base = s * N_COEF;
      acc  = coef_mem[base+COEF_B0] * x + sec_state[2*s];
      y    = (acc + ROUND_HALF) >>> COEF_FRAC;
      if (y > SMP_HI) begin
        y    = SMP_HI;
        clip = 1'b1;
      end else if (y < SMP_LO) begin
        y    = SMP_LO;
        clip = 1'b1;
      end
      sec_state[2*s] = clamp48(coef_mem[base+COEF_B1] * x - coef_mem[base+COEF_A1] * y
                               + sec_state[2*s+1]);
      sec_state[2*s+1] = clamp48(coef_mem[base+COEF_B2] * x - coef_mem[base+COEF_A2] * y);
      x = y;
    end
    res.sample_out    = x[SMP_W-1:0];
    res.clipped       = clip;
    res.block_end_out = it.block_end;
  endtask

  always @(posedge clk) begin
    out_item_t want, got;
    if (!rst_n) begin
      clear_filter();
      filtered_q.delete();
    end else begin
      if (psel && penable && pready && paddr == ADDR_NSEC) begin
        if (pwrite) nsec = pwdata[NSEC_W-1:0];
        else if (prdata !== PDATA_W'(nsec))
          log_error($sformatf("num_sections read: expected %0d, got %0d", nsec, prdata));
      end

      if (in_valid && in_ready) begin
        if (in_data.mode == MODE_COEF) begin
          if (int'(in_data.coef_select) < N_COEF && int'(in_data.section_index) < SECTIONS)
            coef_mem[int'(in_data.section_index)*N_COEF + int'(in_data.coef_select)] =
              longint'($signed(in_data.coef_value));
        end else begin
          run_cascade(in_data, want);
          filtered_q.push_back(want);
        end
      end

      if (out_valid && out_ready) begin
        got = out_data;
        if (filtered_q.size() == 0) begin
          log_error($sformatf("result with no sample pending: sample_out %0d",
                              $signed(got.sample_out)));
        end else begin
          want = filtered_q.pop_front();
          if (got.sample_out !== want.sample_out)
            log_error($sformatf("sample_out: expected %0d, got %0d",
                                $signed(want.sample_out), $signed(got.sample_out)));
          if (got.clipped !== want.clipped)
            log_error($sformatf("clipped: expected %0b, got %0b", want.clipped, got.clipped));
          if (got.block_end_out !== want.block_end_out)
            log_error($sformatf("block_end_out: expected %0b, got %0b",
                                want.block_end_out, got.block_end_out));
        end
      end
    end
    n_pending = filtered_q.size();
  end

endmodule

### test/tb_top.sv
// stimulus, flow control and verdict for the biquad cascade filter
`timescale 1ns / 1ps

module tb_top;
  import biq_pkg::*;

  localparam int N_ITEMS      = 1600;
  localparam int DRAIN_CYCLES = 64;    // well past eight sections of multiply-accumulate
  localparam int HOLD_CYCLES  = 600;   // long receiver hold-off
  localparam int IDLE_PCT     = 38;
  localparam logic [PADDR_W-1:0] ADDR_NSEC   = PADDR_W'(4 * REG_NUM_SECTIONS);
  localparam logic [PADDR_W-1:0] ADDR_BEYOND = PADDR_W'(4 * (REG_NUM_SECTIONS + 1));

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int n_errors;
  int n_pending;
  int n_sent;

  // flow-control knobs, written with nonblocking assignments at falling edges
  bit steady;    // no idling on either side
  bit hold_go;   // ask the receiver for its one long hold-off

  biquad_cascade_filter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  biq_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .n_errors  (n_errors),
    .n_pending (n_pending)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // safety net against a hung handshake, far beyond the slowest clean run
  initial begin
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // receiver: random stalls, a calm stretch, and one long hold-off counted here
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held      = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !held) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // one request on the input channel; entered and left at a falling edge
  task automatic send_item(input in_item_t it);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // sample request; the coefficient fields carry random don't-care bits
  task automatic send_sample(input logic [SMP_W-1:0] smp, input logic be);
    in_item_t it;
    it.mode          = MODE_SAMPLE;
    it.sample_in     = smp;
    it.block_end     = be;
    it.section_index = 3'($urandom);
    it.coef_select   = 3'($urandom);
    it.coef_value    = COEF_W'($urandom);
    send_item(it);
    n_sent++;
  endtask

  // coefficient request; sample fields are don't-care
  task automatic send_coef(input int sec, input int sel, input logic [COEF_W-1:0] val);
    in_item_t it;
    it.mode          = MODE_COEF;
    it.sample_in     = SMP_W'($urandom);
    it.block_end     = 1'($urandom);
    it.section_index = 3'(sec);
    it.coef_select   = 3'(sel);
    it.coef_value    = val;
    send_item(it);
    if (sel < N_COEF) n_sent++;
  endtask

  // one APB transfer: setup cycle, then access until pready
  task automatic apb_access(input bit wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // stop offering, wait for every pending result, then let the pipeline drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // new section count only while idle; upper data bits are junk the register drops
  task automatic set_sections(input int n);
    wait_idle();
    apb_access(1'b1, ADDR_NSEC, {28'($urandom), 4'(n)});
    apb_access(1'b0, ADDR_NSEC, '0);
  endtask

  // mostly moderate coefficients, now and then full-scale or arbitrary ones
  function automatic logic [COEF_W-1:0] pick_coef(input int sel);
    int span;
    case (sel)
      COEF_A1: span = 3 << 21;     // about 1.5
      COEF_A2: span = 2516582;     // about 0.6
      default: span = 1 << 21;     // about 0.5
    endcase
    case ($urandom_range(0, 9))
      0:       return COEF_W'($urandom);
      1:       return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
      2:       return COEF_UNITY;
      default: return COEF_W'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  function automatic logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2, 3:    return SMP_W'($urandom);
      default: return SMP_W'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  // a full coefficient set for one section, sometimes with an unknown selector
  task automatic load_section(input int sec);
    for (int k = 0; k < N_COEF; k++) send_coef(sec, k, pick_coef(k));
    if ($urandom_range(0, 3) == 0)
      send_coef(sec, $urandom_range(N_COEF, 7), COEF_W'($urandom));
  endtask

  // samples grouped in caller blocks, with stray coefficient writes as noise
  task automatic sample_burst(input int count);
    int left_in_block;
    left_in_block = $urandom_range(1, 32);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0)
        send_coef($urandom_range(0, 7), $urandom_range(0, 7), COEF_W'($urandom));
      left_in_block--;
      send_sample(pick_sample(), left_in_block == 0);
      if (left_in_block == 0) left_in_block = $urandom_range(1, 32);
    end
  endtask

  initial begin
    int phase, n_use, n_cfg;
    // every block input known from time zero
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    steady   <= 1'b0;
    hold_go  <= 1'b0;
    n_sent   = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset coefficients: one section, unity pass-through at the sample extremes and near zero
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b1);

    // largest and smallest b0 drive the output into saturation
    send_coef(0, COEF_B0, 24'h7F_FFFF);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    // unknown selectors must leave the store alone
    send_coef(0, N_COEF, 24'h12_3456);
    send_coef(0, 7, 24'h80_0000);
    send_coef(0, COEF_B0, 24'h80_0000);
    send_sample(16'h8000, 1'b0);

    // every coefficient of section zero, feedback at full scale
    send_coef(0, COEF_B0, COEF_UNITY);
    send_coef(0, COEF_B1, 24'h20_0000);
    send_coef(0, COEF_B2, 24'h80_0000);
    send_coef(0, COEF_A1, 24'h7F_FFFF);
    send_coef(0, COEF_A2, 24'h40_0000);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'h0064, 1'b0);

    // a write past the register list is dropped
    wait_idle();
    apb_access(1'b1, ADDR_BEYOND, 32'h0000_0000);
    apb_access(1'b0, ADDR_NSEC, '0);

    // zero sections bypass the cascade
    set_sections(0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);

    // a count above the section total acts as all sections
    set_sections(15);
    send_sample(16'h4000, 1'b0);
    send_sample(16'h8000, 1'b1);

    // random phases: new count, fresh coefficients, then a burst of samples
    phase = 0;
    while (n_sent < N_ITEMS) begin
      case (phase % 6)
        0:       n_cfg = SECTIONS;
        1:       n_cfg = 1;
        2:       n_cfg = (phase % 12 == 2) ? 0 : 15;
        default: n_cfg = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(1, SECTIONS);
      endcase
      set_sections(n_cfg);
      steady <= (phase == 2);
      if (phase == 3) hold_go <= 1'b1;
      n_use = (n_cfg > SECTIONS) ? SECTIONS : n_cfg;
      if ($urandom_range(0, 3) == 0) n_use = SECTIONS;
      for (int s = 0; s < n_use; s++) load_section(s);
      sample_burst($urandom_range(60, 140));
      phase++;
    end

    // all offered; wait for the last result and a quiet tail
    wait_idle();
    if (n_errors == 0 && n_pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
